FILE: rtl/rolling_standard_deviation_macros.svh
// ----------------------------------------------------------------------------
// rolling standard deviation assertion macros
// shared helpers for the concurrent checks in the rsd modules
// ----------------------------------------------------------------------------
`ifndef ROLLING_STANDARD_DEVIATION_MACROS_SVH
`define ROLLING_STANDARD_DEVIATION_MACROS_SVH

// same-cycle implication
`define RSD_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/rsd_pkg.sv
// ----------------------------------------------------------------------------
// rsd_pkg
// types, constants and width helpers for the rolling standard deviation block
// ----------------------------------------------------------------------------
package rsd_pkg;

   localparam int SAMPLE_W       = 24;
   localparam int STD_W          = 24;
   localparam int CSR_W          = 7;
   localparam int MAX_WINDOW_DEF = 64;
   localparam int QUEUE_DEPTH    = 2;

   localparam logic [CSR_W-1:0] WINDOW_LEN_RESET = 7'd20;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       start_of_series;
   } req_type;

   typedef struct packed {
      logic [STD_W-1:0] std_dev;
      logic             window_full;
   } rsp_type;

   function automatic int len_width(input int max_window);
      return $clog2(max_window + 1);
   endfunction

   function automatic int addr_width(input int max_window);
      return (max_window > 1) ? $clog2(max_window) : 1;
   endfunction

   function automatic int sum_width(input int max_window);
      return len_width(max_window) + SAMPLE_W;
   endfunction

   function automatic int sumsq_width(input int max_window);
      return len_width(max_window) + 2 * SAMPLE_W - 2;
   endfunction

   function automatic int mid_width(input int max_window);
      return 1 + len_width(max_window) + sumsq_width(max_window) + sum_width(max_window);
   endfunction

   function automatic logic [SAMPLE_W-1:0] sample_mag(input logic signed [SAMPLE_W-1:0] v);
      logic [SAMPLE_W-1:0] u;
      u = v;
      return u[SAMPLE_W-1] ? SAMPLE_W'(~u + 1'b1) : u;
   endfunction

endpackage

FILE: rtl/rsd_fifo.sv
// ----------------------------------------------------------------------------
// rsd_fifo
// short register queue, one word in and one word out per cycle; a push is refused while full and a pop while empty
// ----------------------------------------------------------------------------
module rsd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = rsd_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push_ok;
   logic             pop_ok;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign push_ok = push && !full;
   assign pop_ok  = pop && !empty;
   assign rdata   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         entry_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

FILE: rtl/rsd_front.sv
// ----------------------------------------------------------------------------
// rsd_front
// sample ring, running sum and sum of squares; one word per sample to the back
// ----------------------------------------------------------------------------
`include "rolling_standard_deviation_macros.svh"

module rsd_front #(
   parameter int MAX_WINDOW = rsd_pkg::MAX_WINDOW_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_push,
   input  rsd_pkg::req_type                       req_data,
   output logic                                   req_full,
   input  logic                                   csr_we,
   input  logic [rsd_pkg::CSR_W-1:0]              csr_wdata,
   output logic                                   mid_push,
   output logic [rsd_pkg::mid_width(MAX_WINDOW)-1:0] mid_data,
   input  logic                                   mid_full
);

   localparam int SAMPLE_W  = rsd_pkg::SAMPLE_W;
   localparam int CSR_W     = rsd_pkg::CSR_W;
   localparam int ADDR_W    = rsd_pkg::addr_width(MAX_WINDOW);
   localparam int LEN_W     = rsd_pkg::len_width(MAX_WINDOW);
   localparam int SUM_W     = rsd_pkg::sum_width(MAX_WINDOW);
   localparam int SQ_W      = rsd_pkg::sumsq_width(MAX_WINDOW);
   localparam int MAG_SQ_W  = 2 * SAMPLE_W - 1;
   localparam int EXT_W     = (LEN_W > CSR_W) ? LEN_W : CSR_W;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SQUARE = 2'd1;
   localparam logic [1:0] ST_UPDATE = 2'd2;

   logic [1:0]                 state_ff, state_in;
   logic [CSR_W-1:0]           window_len_ff, window_len_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic [SQ_W-1:0]            sumsq_ff, sumsq_in;
   logic [LEN_W-1:0]           seen_ff, seen_in;
   logic [ADDR_W-1:0]          slot_ff, slot_in;
   logic [ADDR_W-1:0]          cur_ff, cur_in;
   logic                       evict_ff, evict_in;
   logic signed [SAMPLE_W-1:0] x_ff, x_in;
   logic [MAG_SQ_W-1:0]        xsq_ff, xsq_in;
   logic [MAG_SQ_W-1:0]        oldsq_ff, oldsq_in;
   logic signed [SAMPLE_W-1:0] rd_ff;

   logic signed [SAMPLE_W-1:0] store_mem [MAX_WINDOW];

   logic [EXT_W-1:0]           len_ext;
   logic [LEN_W-1:0]           n_eff;
   logic [ADDR_W-1:0]          base_slot;
   logic [LEN_W-1:0]           base_seen;
   logic [LEN_W-1:0]           slot_next;
   logic [2*SAMPLE_W-1:0]      xprod;
   logic [2*SAMPLE_W-1:0]      oldprod;
   logic [SAMPLE_W-1:0]        x_mag;
   logic [SAMPLE_W-1:0]        rd_mag;
   logic signed [SUM_W-1:0]    old_ext;
   logic signed [SUM_W-1:0]    x_ext;
   logic                       accept;
   logic                       commit;
   logic                       window_full;

   // effective window length: zero reads as one, above the ring size saturates
   always_comb begin
      len_ext = EXT_W'(window_len_ff);
      if (len_ext == '0) begin
         n_eff = LEN_W'(1);
      end else if (len_ext > EXT_W'(MAX_WINDOW)) begin
         n_eff = LEN_W'(MAX_WINDOW);
      end else begin
         n_eff = LEN_W'(len_ext);
      end
   end

   assign req_full = (state_ff != ST_IDLE);
   assign accept   = req_push && (state_ff == ST_IDLE);
   assign commit   = (state_ff == ST_UPDATE) && !mid_full;
   assign mid_push = commit;

   assign x_mag   = rsd_pkg::sample_mag(req_data.sample);
   assign rd_mag  = rsd_pkg::sample_mag(rd_ff);
   assign xprod   = x_mag * x_mag;
   assign oldprod = rd_mag * rd_mag;
   assign old_ext = evict_ff ? SUM_W'(rd_ff) : '0;
   assign x_ext   = SUM_W'(x_ff);

   always_comb begin
      state_in      = state_ff;
      window_len_in = window_len_ff;
      sum_in        = sum_ff;
      sumsq_in      = sumsq_ff;
      seen_in       = seen_ff;
      slot_in       = slot_ff;
      cur_in        = cur_ff;
      evict_in      = evict_ff;
      x_in          = x_ff;
      xsq_in        = xsq_ff;
      oldsq_in      = oldsq_ff;
      base_slot     = req_data.start_of_series ? '0 : slot_ff;
      base_seen     = req_data.start_of_series ? '0 : seen_ff;
      slot_next     = LEN_W'(cur_ff) + LEN_W'(1);
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cur_in   = (LEN_W'(base_slot) >= n_eff) ? '0 : base_slot;
               evict_in = (base_seen >= n_eff);
               x_in     = req_data.sample;
               xsq_in   = xprod[MAG_SQ_W-1:0];
               if (req_data.start_of_series) begin
                  sum_in   = '0;
                  sumsq_in = '0;
                  seen_in  = '0;
               end
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            oldsq_in = evict_ff ? oldprod[MAG_SQ_W-1:0] : '0;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (commit) begin
               sum_in   = sum_ff - old_ext + x_ext;
               sumsq_in = sumsq_ff - SQ_W'(oldsq_ff) + SQ_W'(xsq_ff);
               seen_in  = evict_ff ? seen_ff : seen_ff + 1'b1;
               slot_in  = (slot_next >= n_eff) ? '0 : ADDR_W'(slot_next);
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // a new window length restarts the series
      if (csr_we) begin
         window_len_in = csr_wdata;
         sum_in        = '0;
         sumsq_in      = '0;
         seen_in       = '0;
         slot_in       = '0;
      end
   end

   assign window_full = (seen_in >= n_eff);
   assign mid_data    = {window_full, n_eff, sumsq_in, sum_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         window_len_ff <= rsd_pkg::WINDOW_LEN_RESET;
         sum_ff        <= '0;
         sumsq_ff      <= '0;
         seen_ff       <= '0;
         slot_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         window_len_ff <= window_len_in;
         sum_ff        <= sum_in;
         sumsq_ff      <= sumsq_in;
         seen_ff       <= seen_in;
         slot_ff       <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      evict_ff <= evict_in;
      x_ff     <= x_in;
      xsq_ff   <= xsq_in;
      oldsq_ff <= oldsq_in;
   end

   // sample ring
   always_ff @(posedge clock) begin
      if (commit) begin
         store_mem[cur_ff] <= x_ff;
      end
      if (accept) begin
         rd_ff <= store_mem[cur_in];
      end
   end

   `RSD_ASSERT_IMPLIES(a_seen_bounded, clock, reset, 1'b1, seen_ff <= n_eff, "sample count past window")
   `RSD_ASSERT_IMPLIES(a_evict_full, clock, reset, (state_ff == ST_UPDATE) && evict_ff, seen_ff == n_eff, "eviction before window full")
   `RSD_ASSERT_NEXT(a_csr_clears, clock, reset, csr_we, (seen_ff == '0) && (sum_ff == '0) && (slot_ff == '0), "history not cleared on window write")

endmodule

FILE: rtl/rsd_back.sv
// ----------------------------------------------------------------------------
// rsd_back
// variance numerator, bit-serial square root and divide by the window length
// ----------------------------------------------------------------------------
`include "rolling_standard_deviation_macros.svh"

module rsd_back #(
   parameter int MAX_WINDOW = rsd_pkg::MAX_WINDOW_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   output logic                                      mid_pop,
   input  logic [rsd_pkg::mid_width(MAX_WINDOW)-1:0] mid_data,
   input  logic                                      mid_empty,
   output logic                                      out_push,
   output rsd_pkg::rsp_type                          out_data,
   input  logic                                      out_full
);

   localparam int STD_W = rsd_pkg::STD_W;
   localparam int LEN_W = rsd_pkg::len_width(MAX_WINDOW);
   localparam int SUM_W = rsd_pkg::sum_width(MAX_WINDOW);
   localparam int SQ_W  = rsd_pkg::sumsq_width(MAX_WINDOW);
   localparam int MID_W = rsd_pkg::mid_width(MAX_WINDOW);
   localparam int RT_W  = SUM_W - 1;
   localparam int D_W   = 2 * RT_W;
   localparam int REM_W = RT_W + 2;
   localparam int SH_W  = RT_W + 4;
   localparam int CNT_W = $clog2(RT_W + 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_MULT   = 3'd1;
   localparam logic [2:0] ST_SUBTR  = 3'd2;
   localparam logic [2:0] ST_ROOT   = 3'd3;
   localparam logic [2:0] ST_DIVIDE = 3'd4;
   localparam logic [2:0] ST_OUTPUT = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [LEN_W-1:0] n_ff, n_in;
   logic             full_ff, full_in;
   logic [RT_W-1:0]  mag_ff, mag_in;
   logic [D_W-1:0]   mcand_ff, mcand_in;
   logic [LEN_W-1:0] mplier_ff, mplier_in;
   logic [D_W-1:0]   acc_ff, acc_in;
   logic [D_W-1:0]   sq_ff, sq_in;
   logic [D_W-1:0]   rad_ff, rad_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [RT_W-1:0]  root_ff, root_in;
   logic [LEN_W-1:0] drem_ff, drem_in;
   logic [CNT_W-1:0] step_ff, step_in;

   logic [SUM_W-1:0] e_sum;
   logic [SQ_W-1:0]  e_sumsq;
   logic [LEN_W-1:0] e_n;
   logic             e_full;
   logic [SUM_W-1:0] e_mag;
   logic [D_W-1:0]   sq_prod;
   logic [SH_W-1:0]  rem_sh;
   logic [SH_W-1:0]  trial;
   logic [LEN_W:0]   dsh;
   logic [LEN_W:0]   n_ext;
   logic             last_step;

   assign e_sum   = mid_data[SUM_W-1:0];
   assign e_sumsq = mid_data[SUM_W +: SQ_W];
   assign e_n     = mid_data[SUM_W+SQ_W +: LEN_W];
   assign e_full  = mid_data[MID_W-1];
   assign e_mag   = e_sum[SUM_W-1] ? SUM_W'(~e_sum + 1'b1) : e_sum;

   assign sq_prod   = mag_ff * mag_ff;
   assign rem_sh    = {rem_ff, rad_ff[D_W-1 -: 2]};
   assign trial     = SH_W'({root_ff, 2'b01});
   assign dsh       = {drem_ff, root_ff[RT_W-1]};
   assign n_ext     = (LEN_W + 1)'(n_ff);
   assign last_step = (step_ff == CNT_W'(1));

   assign mid_pop  = (state_ff == ST_IDLE) && !mid_empty;
   assign out_push = (state_ff == ST_OUTPUT) && !out_full;

   always_comb begin
      out_data.std_dev     = full_ff ? root_ff[STD_W-1:0] : '0;
      out_data.window_full = full_ff;
   end

   always_comb begin
      state_in  = state_ff;
      n_in      = n_ff;
      full_in   = full_ff;
      mag_in    = mag_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      sq_in     = sq_ff;
      rad_in    = rad_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      drem_in   = drem_ff;
      step_in   = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (mid_pop) begin
               n_in      = e_n;
               full_in   = e_full;
               mag_in    = RT_W'(e_mag);
               mcand_in  = D_W'(e_sumsq);
               mplier_in = e_n;
               acc_in    = '0;
               step_in   = CNT_W'(LEN_W);
               state_in  = e_full ? ST_MULT : ST_OUTPUT;
            end
         end
         ST_MULT: begin
            // n * sumsq by shift and add, sum squared alongside
            if (mplier_ff[0]) begin
               acc_in = acc_ff + mcand_ff;
            end
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            sq_in     = sq_prod;
            step_in   = step_ff - 1'b1;
            if (last_step) begin
               state_in = ST_SUBTR;
            end
         end
         ST_SUBTR: begin
            rad_in   = (acc_ff >= sq_ff) ? acc_ff - sq_ff : '0;
            rem_in   = '0;
            root_in  = '0;
            step_in  = CNT_W'(RT_W);
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (rem_sh >= trial) begin
               rem_in  = REM_W'(rem_sh - trial);
               root_in = {root_ff[RT_W-2:0], 1'b1};
            end else begin
               rem_in  = REM_W'(rem_sh);
               root_in = {root_ff[RT_W-2:0], 1'b0};
            end
            rad_in  = rad_ff << 2;
            step_in = step_ff - 1'b1;
            if (last_step) begin
               drem_in  = '0;
               step_in  = CNT_W'(RT_W);
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            // root over n, quotient shifts into the root register
            if (dsh >= n_ext) begin
               drem_in = LEN_W'(dsh - n_ext);
               root_in = {root_ff[RT_W-2:0], 1'b1};
            end else begin
               drem_in = LEN_W'(dsh);
               root_in = {root_ff[RT_W-2:0], 1'b0};
            end
            step_in = step_ff - 1'b1;
            if (last_step) begin
               state_in = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            if (out_push) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff      <= n_in;
      full_ff   <= full_in;
      mag_ff    <= mag_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
      sq_ff     <= sq_in;
      rad_ff    <= rad_in;
      rem_ff    <= rem_in;
      root_ff   <= root_in;
      drem_ff   <= drem_in;
      step_ff   <= step_in;
   end

   `RSD_ASSERT_IMPLIES(a_arith_full, clock, reset, (state_ff == ST_MULT) || (state_ff == ST_ROOT) || (state_ff == ST_DIVIDE), full_ff, "arithmetic on a short window")
   `RSD_ASSERT_IMPLIES(a_root_rem, clock, reset, state_ff == ST_ROOT, rem_ff <= REM_W'({root_ff, 1'b0}), "root remainder out of range")
   `RSD_ASSERT_IMPLIES(a_div_rem, clock, reset, state_ff == ST_DIVIDE, drem_ff < n_ff, "divide remainder not below window length")

endmodule

FILE: rtl/rolling_standard_deviation.sv
// ----------------------------------------------------------------------------
// rolling_standard_deviation
// population standard deviation of a Q.8 sample stream over a sliding window
// ----------------------------------------------------------------------------
// The front end takes one sample at a time (accept and ring read, square of
// the leaving sample, sum update) and hands each word to the back end through
// a two-word queue. On a full window the back end is the slower side: it works
// on one sample at a time through the shift-add multiply, the one bit a cycle
// square root and the one bit a cycle divide by the window length (the default
// ring size is 64); a sample before the window fills skips these and goes
// straight to output. Results wait in a two-word output queue. Writing the
// window length clears the history; there is no clearing pass after reset.
module rolling_standard_deviation #(
   parameter int MAX_WINDOW = rsd_pkg::MAX_WINDOW_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   input  rsd_pkg::req_type          req_data,
   output logic                      req_full,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output rsd_pkg::rsp_type          rsp_data,
   input  logic                      csr_we,
   input  logic [rsd_pkg::CSR_W-1:0] csr_wdata
);

   localparam int MID_W = rsd_pkg::mid_width(MAX_WINDOW);
   localparam int RSP_W = $bits(rsd_pkg::rsp_type);

   logic             mid_push;
   logic [MID_W-1:0] mid_wdata;
   logic             mid_full;
   logic             mid_pop;
   logic [MID_W-1:0] mid_rdata;
   logic             mid_empty;
   logic             out_push;
   rsd_pkg::rsp_type out_data;
   logic [RSP_W-1:0] out_wdata;
   logic [RSP_W-1:0] out_rdata;
   logic             out_full;

   assign out_wdata = RSP_W'(out_data);
   assign rsp_data  = rsd_pkg::rsp_type'(out_rdata);

   rsd_front #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .mid_push  (mid_push),
      .mid_data  (mid_wdata),
      .mid_full  (mid_full)
   );

   rsd_fifo #(
      .WIDTH (MID_W),
      .DEPTH (rsd_pkg::QUEUE_DEPTH)
   ) u_mid_fifo (
      .clock (clock),
      .reset (reset),
      .push  (mid_push),
      .wdata (mid_wdata),
      .full  (mid_full),
      .pop   (mid_pop),
      .rdata (mid_rdata),
      .empty (mid_empty)
   );

   rsd_back #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_pop   (mid_pop),
      .mid_data  (mid_rdata),
      .mid_empty (mid_empty),
      .out_push  (out_push),
      .out_data  (out_data),
      .out_full  (out_full)
   );

   rsd_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (rsd_pkg::QUEUE_DEPTH)
   ) u_out_fifo (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (out_wdata),
      .full  (out_full),
      .pop   (rsp_pop),
      .rdata (out_rdata),
      .empty (rsp_empty)
   );

endmodule

FILE: test/rolling_standard_deviation_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rolling standard deviation testbench
// drives sample words through the push/full port and checks every result word
// popped from the empty/pop port against an in-bench windowed predictor, over
// several window lengths, with random gaps on both sides and one long backlog
// ----------------------------------------------------------------------------
module rolling_standard_deviation_test;

   localparam int MAX_WINDOW  = rsd_pkg::MAX_WINDOW_DEF;
   localparam int SAMPLE_W    = rsd_pkg::SAMPLE_W;
   localparam int STD_W       = rsd_pkg::STD_W;
   localparam int CSR_W       = rsd_pkg::CSR_W;
   localparam int STALL_LIMIT = 5000;
   localparam int BACKLOG_LEN = 400;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_push  = 1'b0;
   rsd_pkg::req_type req_data  = '0;
   logic             req_full;
   logic             rsp_empty;
   logic             rsp_pop   = 1'b0;
   rsd_pkg::rsp_type rsp_data;
   logic             csr_we    = 1'b0;
   logic [CSR_W-1:0] csr_wdata = '0;

   rsd_pkg::req_type pending_words[$];
   rsd_pkg::rsp_type expected_words[$];

   // predictor state
   logic signed [SAMPLE_W-1:0] window_copy [MAX_WINDOW];
   longint                     win_sum;
   logic [63:0]                win_sum_sq;
   int                         win_count;
   int                         win_slot;
   logic [CSR_W-1:0]           win_len_reg;

   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   int   error_count   = 0;
   int   results_seen  = 0;
   int   stall_cycles  = 0;
   logic word_in_taken = 1'b0;
   int   hold_left     = 0;
   bit   backlog_done  = 1'b0;

   rolling_standard_deviation i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic logic [31:0] floor_sqrt(input logic [63:0] v);
      logic [31:0] root;
      logic [31:0] trial;
      root = '0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (32'd1 << b);
         if (64'(trial) * 64'(trial) <= v) begin
            root = trial;
         end
      end
      return root;
   endfunction

   task automatic clear_window();
      foreach (window_copy[i]) window_copy[i] = '0;
      win_sum    = 0;
      win_sum_sq = '0;
      win_count  = 0;
      win_slot   = 0;
   endtask

   task automatic advance_window(input rsd_pkg::req_type w, output rsd_pkg::rsp_type r);
      int          n;
      longint      x;
      longint      old;
      logic [63:0] num;
      logic [63:0] sq;
      logic [63:0] diff;
      logic [31:0] root;
      n = (win_len_reg == 0) ? 1 : (win_len_reg > MAX_WINDOW) ? MAX_WINDOW : int'(win_len_reg);
      x = longint'(w.sample);
      if (w.start_of_series) begin
         clear_window();
      end
      if (win_slot >= n) begin
         win_slot = 0;
      end
      if (win_count >= n) begin
         old        = longint'(window_copy[win_slot]);
         win_sum    = win_sum - old;
         win_sum_sq = win_sum_sq - 64'(old * old);
      end else begin
         win_count++;
      end
      window_copy[win_slot] = w.sample;
      win_sum    = win_sum + x;
      win_sum_sq = win_sum_sq + 64'(x * x);
      win_slot   = (win_slot + 1 >= n) ? 0 : win_slot + 1;
      r = '0;
      if (win_count >= n) begin
         num  = 64'(n) * win_sum_sq;
         sq   = 64'(win_sum * win_sum);
         diff = (num >= sq) ? num - sq : 64'd0;
         root = floor_sqrt(diff / (64'(n) * 64'(n)));
         r.std_dev     = root[STD_W-1:0];
         r.window_full = 1'b1;
      end
   endtask

   task automatic report_mismatch(input string what);
      $display("mismatch on result word %0d: %s", results_seen, what);
      error_count++;
   endtask

   // monitor and predictor
   always @(posedge clock) begin : monitor
      logic             word_out_taken;
      rsd_pkg::rsp_type want;
      rsd_pkg::rsp_type predicted;
      if (reset) begin
         clear_window();
         win_len_reg   = rsd_pkg::WINDOW_LEN_RESET;
         word_in_taken = 1'b0;
         stall_cycles  = 0;
      end else begin
         word_in_taken  = req_push && !req_full;
         word_out_taken = rsp_pop && !rsp_empty;
         if (csr_we) begin
            win_len_reg = csr_wdata;
            clear_window();
         end
         if (word_out_taken) begin
            if (expected_words.size() == 0) begin
               report_mismatch("word with nothing expected");
            end else begin
               want = expected_words.pop_front();
               if (rsp_data.std_dev !== want.std_dev) begin
                  report_mismatch($sformatf("std_dev %0h, expected %0h",
                                            rsp_data.std_dev, want.std_dev));
               end
               if (rsp_data.window_full !== want.window_full) begin
                  report_mismatch($sformatf("window_full %b, expected %b",
                                            rsp_data.window_full, want.window_full));
               end
            end
            results_seen++;
         end
         if (word_in_taken) begin
            advance_window(req_data, predicted);
            expected_words.push_back(predicted);
         end
         stall_cycles = (word_in_taken || word_out_taken) ? 0 : stall_cycles + 1;
      end
   end

   // sample driver
   always @(negedge clock) begin : driver
      if (reset) begin
         req_push <= 1'b0;
      end else if (!req_push || word_in_taken) begin
         if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_data <= pending_words.pop_front();
            req_push <= 1'b1;
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // result receiver, with one long hold to back the block up
   always @(negedge clock) begin : receiver
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_pop <= 1'b0;
      end else if (!backlog_done && results_seen >= 200) begin
         backlog_done = 1'b1;
         hold_left    = BACKLOG_LEN;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin : watchdog
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("Verification failed");
      $finish;
   end

   task automatic add_word(input logic signed [SAMPLE_W-1:0] s, input logic sos);
      rsd_pkg::req_type w;
      w.sample          = s;
      w.start_of_series = sos;
      pending_words.push_back(w);
   endtask

   task automatic add_random_words(input int count, input int sos_pct);
      logic signed [SAMPLE_W-1:0] base;
      logic signed [SAMPLE_W-1:0] s;
      base = SAMPLE_W'($urandom);
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(9)) inside
            0: s = SAMPLE_MIN;
            1: s = SAMPLE_MAX;
            [2:4]: s = SAMPLE_W'($urandom);
            default: s = base + SAMPLE_W'($urandom_range(8191)) - SAMPLE_W'(4096);
         endcase
         add_word(s, $urandom_range(99) < sos_pct);
      end
   endtask

   // checked at the rising edge, where the driver's outputs are settled
   task automatic drain();
      while (pending_words.size() != 0 || req_push || expected_words.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_window_len(input logic [CSR_W-1:0] v);
      drain();
      @(negedge clock);
      csr_wdata <= v;
      csr_we    <= 1'b1;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin : stimulus
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 11;
      recv_idle_pct = 52;
      add_random_words(80, 3);

      write_window_len(7'd2);
      add_word(SAMPLE_MAX, 1'b1);
      add_word(SAMPLE_MAX, 1'b0);
      add_word(SAMPLE_MIN, 1'b0);
      add_word(SAMPLE_MIN, 1'b0);
      add_word(24'sd1, 1'b0);
      add_word(-24'sd1, 1'b0);
      add_word(24'sd0, 1'b0);
      add_word(24'sd0, 1'b0);
      add_word(-24'sd5, 1'b1);
      add_word(24'sd7, 1'b1);
      add_word(24'sd9, 1'b0);
      add_word(SAMPLE_MAX, 1'b0);
      add_word(24'sd0, 1'b0);
      add_word(24'sh400000, 1'b0);
      add_word(-24'sh400000, 1'b0);
      add_word(24'sh000100, 1'b0);
      add_word(24'sh000300, 1'b0);
      add_word(SAMPLE_MIN, 1'b1);
      add_word(SAMPLE_MIN, 1'b0);
      add_word(SAMPLE_MAX, 1'b0);
      add_word(24'sh555555, 1'b0);
      add_word(-24'sh2AAAAB, 1'b0);

      write_window_len(7'd1);
      add_random_words(60, 5);
      write_window_len(7'd64);
      add_random_words(220, 1);

      send_idle_pct = 52;
      recv_idle_pct = 11;
      write_window_len(7'd0);
      add_random_words(50, 5);
      write_window_len(7'd127);
      add_random_words(200, 1);
      write_window_len(7'd65);
      add_random_words(80, 1);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_window_len(7'd3);
      add_random_words(60, 5);
      write_window_len(CSR_W'($urandom_range(63, 4)));
      add_random_words(100, 2);

      drain();
      repeat (200) @(posedge clock);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
